/* rtl/core/accel_activity_detector_defines.svh */
// Assertion macros for the activity detector checker.
// Needs nothing else; included by the checker file only.
`ifndef ACCEL_ACTIVITY_DETECTOR_DEFINES_SVH
`define ACCEL_ACTIVITY_DETECTOR_DEFINES_SVH

// Clocked check, masked while reset is high.
`define AAD_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define AAD_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/aad_pkg.sv */
// Shared types and constants of the activity detector.
// No dependencies; imported by every module of the block but aad_ram.
package aad_pkg;

   localparam int unsigned AAD_WINDOW_LEN = 8;
   localparam int unsigned AAD_AXES       = 3;
   localparam int unsigned AAD_SAMPLE_W   = 16;
   localparam int unsigned AAD_THR_W      = 15;
   localparam int unsigned AAD_LEVEL_W    = 8;
   localparam int unsigned AAD_CSR_IDX_W  = 3;
   localparam int unsigned AAD_CSR_DATA_W = 15;

   // classification queue between front and back
   localparam int unsigned AAD_QUEUE_DEPTH = 4;
   localparam int unsigned AAD_QPTR_W      = 2;
   localparam int unsigned AAD_QCNT_W      = 3;

   // register indexes
   localparam logic [AAD_CSR_IDX_W-1:0] AAD_REG_THRESHOLD  = 3'd0;
   localparam logic [AAD_CSR_IDX_W-1:0] AAD_REG_RISE_STEP  = 3'd1;
   localparam logic [AAD_CSR_IDX_W-1:0] AAD_REG_DROP_STEP  = 3'd2;
   localparam logic [AAD_CSR_IDX_W-1:0] AAD_REG_LEVEL_MAX  = 3'd3;
   localparam logic [AAD_CSR_IDX_W-1:0] AAD_REG_LEVEL_MIN  = 3'd4;
   localparam logic [AAD_CSR_IDX_W-1:0] AAD_REG_ACTIVE_LIM = 3'd5;
   localparam logic [AAD_CSR_IDX_W-1:0] AAD_REG_REST_LIM   = 3'd6;

   // register reset values
   localparam logic [AAD_THR_W-1:0]   AAD_THRESHOLD_RST  = 15'd778;
   localparam logic [AAD_LEVEL_W-1:0] AAD_RISE_STEP_RST  = 8'd7;
   localparam logic [AAD_LEVEL_W-1:0] AAD_DROP_STEP_RST  = 8'd5;
   localparam logic [AAD_LEVEL_W-1:0] AAD_LEVEL_MAX_RST  = 8'd70;
   localparam logic [AAD_LEVEL_W-1:0] AAD_LEVEL_MIN_RST  = 8'd0;
   localparam logic [AAD_LEVEL_W-1:0] AAD_ACTIVE_LIM_RST = 8'd50;
   localparam logic [AAD_LEVEL_W-1:0] AAD_REST_LIM_RST   = 8'd30;

   // level and hysteresis settings seen by the back end
   typedef struct packed {
      logic [AAD_LEVEL_W-1:0] rise_step;
      logic [AAD_LEVEL_W-1:0] drop_step;
      logic [AAD_LEVEL_W-1:0] level_max;
      logic [AAD_LEVEL_W-1:0] level_min;
      logic [AAD_LEVEL_W-1:0] active_limit;
      logic [AAD_LEVEL_W-1:0] rest_limit;
   } aad_lvl_cfg_type;

   // one classified sample
   typedef struct packed {
      logic motion;
      logic warm;
   } aad_cls_type;

endpackage

/* rtl/core/aad_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the sample window of the front end.
module aad_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/aad_front.sv */
// Front end: accepts samples, keeps the ring window and running sums, flags motion.
// Uses aad_pkg and aad_ram; feeds the classification queue.
module aad_front import aad_pkg::*; #(
   parameter int unsigned WINDOW_LEN = AAD_WINDOW_LEN
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [AAD_SAMPLE_W-1:0] req_accel_x,
   input  logic signed [AAD_SAMPLE_W-1:0] req_accel_y,
   input  logic signed [AAD_SAMPLE_W-1:0] req_accel_z,
   input  logic [AAD_THR_W-1:0]           threshold,
   input  logic [AAD_QCNT_W-1:0]          q_count,
   output logic                           push_valid,
   output aad_cls_type                    push_data
);

   localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
   localparam int unsigned SUM_W  = AAD_SAMPLE_W + SLOT_W;
   localparam int unsigned DIFF_W = SUM_W + 1;
   localparam int unsigned SMP_W  = AAD_AXES * AAD_SAMPLE_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
   localparam logic signed [DIFF_W-1:0] WLEN_S = DIFF_W'(WINDOW_LEN);

   // stage A: slot and fill bookkeeping
   logic              accept;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] fill_ff, fill_in;
   logic              wrap_ff, wrap_in;
   logic [SMP_W-1:0]  smp_a;

   // stage B: running-sum update and window write
   logic              vb_ff;
   logic [SLOT_W-1:0] slot_b_ff;
   logic              wrap_b_ff;
   logic              warm_b_ff;
   logic [SMP_W-1:0]  smp_b_ff;
   logic [SMP_W-1:0]  old_smp;
   logic signed [SUM_W-1:0]  sum_ff [AAD_AXES];
   logic signed [SUM_W-1:0]  sum_in [AAD_AXES];
   logic signed [DIFF_W-1:0] wa_in  [AAD_AXES];

   // stage C: deviation test
   logic                     vc_ff;
   logic                     warm_c_ff;
   logic signed [DIFF_W-1:0] wa_c_ff [AAD_AXES];
   logic signed [DIFF_W-1:0] limit;
   logic [AAD_AXES-1:0]      deviates;

   logic [AAD_QCNT_W-1:0] pending;

   // keep room in the queue for everything already in flight
   assign pending   = q_count + AAD_QCNT_W'(vb_ff) + AAD_QCNT_W'(vc_ff);
   assign req_ready = (pending < AAD_QCNT_W'(AAD_QUEUE_DEPTH));
   assign accept    = req_valid & req_ready;
   assign smp_a     = {req_accel_z, req_accel_y, req_accel_x};

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      wrap_in = wrap_ff;
      if (accept) begin
         slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         fill_in = (fill_ff == LAST_SLOT) ? fill_ff : fill_ff + 1'b1;
         wrap_in = wrap_ff | (slot_ff == LAST_SLOT);
      end
   end

   aad_ram #(
      .WIDTH (SMP_W),
      .DEPTH (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (vb_ff),
      .wr_addr (slot_b_ff),
      .wr_data (smp_b_ff),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (old_smp)
   );

   always_comb begin
      logic signed [AAD_SAMPLE_W-1:0] a_new;
      logic signed [AAD_SAMPLE_W-1:0] a_old;
      logic signed [DIFF_W-1:0]       diff;
      limit = $signed({{(DIFF_W-AAD_THR_W){1'b0}}, threshold}) * WLEN_S;
      for (int i = 0; i < AAD_AXES; i++) begin
         a_new = smp_b_ff[i*AAD_SAMPLE_W +: AAD_SAMPLE_W];
         // entries never written yet read as zero
         a_old = wrap_b_ff ? old_smp[i*AAD_SAMPLE_W +: AAD_SAMPLE_W] : '0;
         sum_in[i] = sum_ff[i] + {{(SUM_W-AAD_SAMPLE_W){a_new[AAD_SAMPLE_W-1]}}, a_new}
                     - {{(SUM_W-AAD_SAMPLE_W){a_old[AAD_SAMPLE_W-1]}}, a_old};
         wa_in[i]  = $signed({{(DIFF_W-AAD_SAMPLE_W){a_new[AAD_SAMPLE_W-1]}}, a_new})
                     * WLEN_S;
         diff = {sum_ff[i][SUM_W-1], sum_ff[i]} - wa_c_ff[i];
         deviates[i] = (diff > limit) || (diff < -limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         wrap_ff <= 1'b0;
         vb_ff   <= 1'b0;
         vc_ff   <= 1'b0;
         for (int i = 0; i < AAD_AXES; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         wrap_ff <= wrap_in;
         vb_ff   <= accept;
         vc_ff   <= vb_ff;
         if (vb_ff) begin
            for (int i = 0; i < AAD_AXES; i++) begin
               sum_ff[i] <= sum_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_b_ff <= slot_ff;
         wrap_b_ff <= wrap_ff;
         warm_b_ff <= (fill_in == LAST_SLOT);
         smp_b_ff  <= smp_a;
      end
      if (vb_ff) begin
         warm_c_ff <= warm_b_ff;
         for (int i = 0; i < AAD_AXES; i++) begin
            wa_c_ff[i] <= wa_in[i];
         end
      end
   end

   assign push_valid       = vc_ff;
   assign push_data.motion = |deviates;
   assign push_data.warm   = warm_c_ff;

endmodule

/* rtl/core/aad_fifo.sv */
// Short queue of classified samples between front and back end.
// Uses aad_pkg for the entry type and depth.
module aad_fifo import aad_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  aad_cls_type           push_data,
   output logic                  pop_valid,
   output aad_cls_type           pop_data,
   input  logic                  pop_ready,
   output logic [AAD_QCNT_W-1:0] count
);

   aad_cls_type           entries_ff [AAD_QUEUE_DEPTH];
   logic [AAD_QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AAD_QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AAD_QCNT_W-1:0] count_ff, count_in;
   logic                  pop;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign pop       = pop_valid & pop_ready;
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + AAD_QCNT_W'(push_valid) - AAD_QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/aad_back.sv */
// Back end: shakiness level update, activity hysteresis and result register.
// Uses aad_pkg; drains the classification queue.
module aad_back import aad_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  aad_cls_type            q_data,
   output logic                   q_ready,
   input  aad_lvl_cfg_type        cfg,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_activity_active,
   output logic [AAD_LEVEL_W-1:0] rsp_level_now,
   output logic                   rsp_motion_seen
);

   logic [AAD_LEVEL_W-1:0] level_ff, level_in;
   logic                   active_ff, active_in;
   logic                   rose_ff, rose_in;
   logic                   valid_ff, valid_in;
   logic [AAD_LEVEL_W:0]   raised;
   logic [AAD_LEVEL_W:0]   floor_lvl;
   logic                   pop;

   // advance when the result slot is free or being taken
   assign q_ready = ~valid_ff | rsp_ready;
   assign pop     = q_valid & q_ready;

   assign raised    = {1'b0, level_ff} + {1'b0, cfg.rise_step};
   assign floor_lvl = {1'b0, cfg.level_min} + {1'b0, cfg.drop_step};

   always_comb begin
      level_in  = level_ff;
      rose_in   = 1'b0;
      if (q_data.warm) begin
         if (q_data.motion && (raised <= {1'b0, cfg.level_max})) begin
            level_in = raised[AAD_LEVEL_W-1:0];
            rose_in  = 1'b1;
         end else if ({1'b0, level_ff} >= floor_lvl) begin
            level_in = level_ff - cfg.drop_step;
         end
      end
      if (level_in >= cfg.active_limit) begin
         active_in = 1'b1;
      end else if (level_in < cfg.rest_limit) begin
         active_in = 1'b0;
      end else begin
         active_in = active_ff;
      end
      valid_in = pop | (valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            level_ff  <= level_in;
            active_ff <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rose_ff <= rose_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_activity_active = active_ff;
   assign rsp_level_now       = level_ff;
   assign rsp_motion_seen     = rose_ff;

endmodule

/* rtl/core/accel_activity_detector.sv */
// An accepted item passes front stages B and C and the queue to the result register.
// Throughput: one item per cycle while req_ready is high, which needs room in the queue
// for all items in flight. The running sums and slot state of the front end and the
// level and activity of the back end are the only loops between consecutive items; the
// 4-entry queue absorbs output stalls. Reset (synchronous) clears the window fill state,
// sums, level and activity, and loads register defaults; no clearing pass.
module accel_activity_detector import aad_pkg::*; #(
   parameter int unsigned WINDOW_LEN = AAD_WINDOW_LEN
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [AAD_SAMPLE_W-1:0]  req_accel_x,
   input  logic signed [AAD_SAMPLE_W-1:0]  req_accel_y,
   input  logic signed [AAD_SAMPLE_W-1:0]  req_accel_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_activity_active,
   output logic [AAD_LEVEL_W-1:0]          rsp_level_now,
   output logic                            rsp_motion_seen,
   input  logic                            csr_wr_en,
   input  logic [AAD_CSR_IDX_W-1:0]        csr_index,
   input  logic [AAD_CSR_DATA_W-1:0]       csr_wdata
);

   logic [AAD_THR_W-1:0]  threshold_ff;
   aad_lvl_cfg_type       lvl_cfg_ff;
   logic                  push_valid;
   aad_cls_type           push_data;
   logic                  q_valid;
   aad_cls_type           q_data;
   logic                  q_ready;
   logic [AAD_QCNT_W-1:0] q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff            <= AAD_THRESHOLD_RST;
         lvl_cfg_ff.rise_step    <= AAD_RISE_STEP_RST;
         lvl_cfg_ff.drop_step    <= AAD_DROP_STEP_RST;
         lvl_cfg_ff.level_max    <= AAD_LEVEL_MAX_RST;
         lvl_cfg_ff.level_min    <= AAD_LEVEL_MIN_RST;
         lvl_cfg_ff.active_limit <= AAD_ACTIVE_LIM_RST;
         lvl_cfg_ff.rest_limit   <= AAD_REST_LIM_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            AAD_REG_THRESHOLD:  threshold_ff <= csr_wdata[AAD_THR_W-1:0];
            AAD_REG_RISE_STEP:  lvl_cfg_ff.rise_step <= csr_wdata[AAD_LEVEL_W-1:0];
            AAD_REG_DROP_STEP:  lvl_cfg_ff.drop_step <= csr_wdata[AAD_LEVEL_W-1:0];
            AAD_REG_LEVEL_MAX:  lvl_cfg_ff.level_max <= csr_wdata[AAD_LEVEL_W-1:0];
            AAD_REG_LEVEL_MIN:  lvl_cfg_ff.level_min <= csr_wdata[AAD_LEVEL_W-1:0];
            AAD_REG_ACTIVE_LIM: lvl_cfg_ff.active_limit <= csr_wdata[AAD_LEVEL_W-1:0];
            AAD_REG_REST_LIM:   lvl_cfg_ff.rest_limit <= csr_wdata[AAD_LEVEL_W-1:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   aad_front #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .threshold   (threshold_ff),
      .q_count     (q_count),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   aad_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop_ready  (q_ready),
      .count      (q_count)
   );

   aad_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_data              (q_data),
      .q_ready             (q_ready),
      .cfg                 (lvl_cfg_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_activity_active (rsp_activity_active),
      .rsp_level_now       (rsp_level_now),
      .rsp_motion_seen     (rsp_motion_seen)
   );

endmodule

/* rtl/core/aad_checker.sv */
// Port-level checker for the activity detector, bound to the top level.
// Uses aad_pkg and the assertion macros of accel_activity_detector_defines.svh.
`include "accel_activity_detector_defines.svh"

module aad_checker import aad_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_activity_active,
   input logic [AAD_LEVEL_W-1:0]         rsp_level_now,
   input logic                           rsp_motion_seen,
   input logic                           csr_wr_en,
   input logic [AAD_CSR_IDX_W-1:0]       csr_index,
   input logic [AAD_CSR_DATA_W-1:0]      csr_wdata
);

   // shadow copies of the limits, tracked from the write port
   logic [AAD_LEVEL_W-1:0] max_ff;
   logic [AAD_LEVEL_W-1:0] act_ff;
   logic [AAD_LEVEL_W-1:0] rest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= AAD_LEVEL_MAX_RST;
         act_ff  <= AAD_ACTIVE_LIM_RST;
         rest_ff <= AAD_REST_LIM_RST;
      end else if (csr_wr_en) begin
         if (csr_index == AAD_REG_LEVEL_MAX) begin
            max_ff <= csr_wdata[AAD_LEVEL_W-1:0];
         end
         if (csr_index == AAD_REG_ACTIVE_LIM) begin
            act_ff <= csr_wdata[AAD_LEVEL_W-1:0];
         end
         if (csr_index == AAD_REG_REST_LIM) begin
            rest_ff <= csr_wdata[AAD_LEVEL_W-1:0];
         end
      end
   end

   property p_reset_idle;
      reset |=> (!rsp_valid && req_ready);
   endproperty

   property p_rsp_hold;
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_level_now) &&
                                     $stable(rsp_motion_seen) &&
                                     $stable(rsp_activity_active));
   endproperty

   property p_active_set;
      (rsp_valid && (rsp_level_now >= act_ff)) |-> rsp_activity_active;
   endproperty

   property p_rest_clear;
      (rsp_valid && (rsp_level_now < rest_ff) && (rsp_level_now < act_ff))
         |-> !rsp_activity_active;
   endproperty

   property p_rise_cap;
      (rsp_valid && rsp_motion_seen) |-> (rsp_level_now <= max_ff);
   endproperty

   `AAD_CHECK_ALWAYS(a_reset_idle, clock, p_reset_idle, "not idle after reset")

   `AAD_CHECK(a_rsp_hold, clock, reset, p_rsp_hold, "stalled item changed")

   `AAD_CHECK(a_active_set, clock, reset, p_active_set, "level at active limit but idle")

   `AAD_CHECK(a_rest_clear, clock, reset, p_rest_clear, "level below rest limit but active")

   `AAD_CHECK(a_rise_cap, clock, reset, p_rise_cap, "rise went past level maximum")

endmodule

bind accel_activity_detector aad_checker u_aad_checker (.*);
